[sv/usv_pkg.sv]
`timescale 1ns / 1ps
// Package for the UTF-8 stream validator: continuation rule codes, byte limits
// and the per-view scan state. No dependencies.
package usv_pkg;

    typedef enum logic [2:0] {
        RULE_ANY    = 3'd0,  // 80-BF
        RULE_E0     = 3'd1,  // A0-BF
        RULE_ED     = 3'd2,  // 80-9F
        RULE_F0     = 3'd3,  // 90-BF
        RULE_F4     = 3'd4,  // 80-8F
        RULE_EF     = 3'd5,  // 80-BF, BF selects RULE_EF_BF
        RULE_EF_BF  = 3'd6   // 80-BD
    } rule_t;

    typedef struct packed {
        logic [1:0] pending;
        rule_t      rule;
        logic       err;
    } scan_state_t;

    typedef struct packed {
        logic has_result;
        logic verdict;
    } step_result_t;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;
    localparam logic [7:0] CONT_9F   = 8'h9F;
    localparam logic [7:0] CONT_BD   = 8'hBD;

    localparam scan_state_t SCAN_CLEAR = '{pending: 2'd0, rule: RULE_ANY, err: 1'b0};

endpackage

[sv/utf8_stream_validator.sv]
`timescale 1ns / 1ps
// Top level of the UTF-8 stream validator: input register, scan state and result
// register. Depends on usv_pkg, usv_step and usv_out_stage.
//
//  channel | ports                                         | direction
//  input   | in_valid, in_ready, data_byte, last_byte,     | into block
//          | empty_view                                    |
//  output  | out_valid, out_ready, is_valid                | out of block
//
// One item per cycle unless a verdict waits on a stalled result register; a verdict
// moves from the input register via the step into the result register on out_valid.
// The byte check is a single pass of usv_step between the two registers.
// Reset clears the scan state and both valid flags; no clearing pass.
// A stalled result register holds a verdict item in the input register: in_ready low.
module utf8_stream_validator
    import usv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       empty_view,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_last_reg;
    logic         s1_empty_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    step_result_t result;
    logic         can_push;
    logic         s1_adv;
    logic         push;
    logic         in_take;

    usv_step u_step (
        .state      (state_reg),
        .data_byte  (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .empty_view (s1_empty_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign s1_adv        = s1_valid_reg && (!result.has_result || can_push);
    assign push          = s1_adv && result.has_result;
    assign in_ready      = !s1_valid_reg || s1_adv;
    assign in_take       = in_valid && in_ready;
    assign s1_valid_next = in_take || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= SCAN_CLEAR;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= data_byte;
            s1_last_reg  <= last_byte;
            s1_empty_reg <= empty_view;
        end
    end

    usv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .result    (result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_valid  (is_valid)
    );

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (state_reg == SCAN_CLEAR))
        else $error("scan state not cleared after a verdict");

    a_empty_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_empty_reg) |-> (push && result.verdict))
        else $error("empty view did not give a valid verdict");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && state_reg.err && !s1_last_reg && !s1_empty_reg) |=> state_reg.err)
        else $error("error flag dropped inside a view");

    a_error_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (push && state_reg.err && !s1_empty_reg) |-> !result.verdict)
        else $error("view with an error reported valid");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty input register");

endmodule

[sv/usv_step.sv]
`timescale 1ns / 1ps
// Combinational step of the validator: checks one byte against the scan state
// and gives the next state and the verdict. Depends on usv_pkg.
module usv_step
    import usv_pkg::*;
(
    input  scan_state_t  state,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic         empty_view,
    output scan_state_t  state_next,
    output step_result_t result
);

    scan_state_t taken;
    logic        cont_ok;

    always_comb
    begin
        unique case (state.rule)
            RULE_E0:    cont_ok = (data_byte >= CONT_A0)  && (data_byte <= CONT_MAX);
            RULE_ED:    cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_9F);
            RULE_F0:    cont_ok = (data_byte >= CONT_90)  && (data_byte <= CONT_MAX);
            RULE_F4:    cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_8F);
            RULE_EF_BF: cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_BD);
            default:    cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);
        endcase
    end

    always_comb
    begin
        taken = state;
        if (state.err)
        begin
            taken = state;
        end
        else if (state.pending == 2'd0)
        begin
            priority if (data_byte <= ASCII_MAX)
            begin
                taken = state;
            end
            else if ((data_byte >= LEAD2_MIN) && (data_byte <= LEAD2_MAX))
            begin
                taken.pending = 2'd1;
                taken.rule    = RULE_ANY;
            end
            else if ((data_byte >= LEAD3_MIN) && (data_byte <= LEAD3_MAX))
            begin
                taken.pending = 2'd2;
                priority if (data_byte == LEAD3_MIN)
                    taken.rule = RULE_E0;
                else if (data_byte == LEAD3_SUR)
                    taken.rule = RULE_ED;
                else if (data_byte == LEAD3_MAX)
                    taken.rule = RULE_EF;
                else
                    taken.rule = RULE_ANY;
            end
            else if ((data_byte >= LEAD4_MIN) && (data_byte <= LEAD4_MAX))
            begin
                taken.pending = 2'd3;
                priority if (data_byte == LEAD4_MIN)
                    taken.rule = RULE_F0;
                else if (data_byte == LEAD4_MAX)
                    taken.rule = RULE_F4;
                else
                    taken.rule = RULE_ANY;
            end
            else
            begin
                taken.err = 1'b1;
            end
        end
        else if (!cont_ok)
        begin
            taken.err = 1'b1;
        end
        else
        begin
            taken.pending = state.pending - 2'd1;
            taken.rule    = ((state.rule == RULE_EF) && (data_byte == CONT_MAX))
                            ? RULE_EF_BF : RULE_ANY;
        end
    end

    always_comb
    begin
        if (empty_view)
        begin
            state_next        = SCAN_CLEAR;
            result.has_result = 1'b1;
            result.verdict    = 1'b1;
        end
        else if (last_byte)
        begin
            state_next        = SCAN_CLEAR;
            result.has_result = 1'b1;
            result.verdict    = !taken.err && (taken.pending == 2'd0);
        end
        else
        begin
            state_next        = taken;
            result.has_result = 1'b0;
            result.verdict    = 1'b0;
        end
    end

endmodule

[sv/usv_out_stage.sv]
`timescale 1ns / 1ps
// Result register of the validator with valid/ready toward the consumer.
// Depends on usv_pkg.
module usv_out_stage
    import usv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  step_result_t result,
    output logic         can_push,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         is_valid
);

    logic out_valid_reg;
    logic out_valid_next;
    logic is_valid_reg;

    assign can_push       = !out_valid_reg || out_ready;
    assign out_valid_next = push || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            is_valid_reg <= result.verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_valid  = is_valid_reg;

endmodule
